/* rtl/rast_pkg.sv */
// shared types and constants for the lazy range-assign / range-sum tree
// no dependencies
package rast_pkg;

  localparam int SUM_W = 42;
  localparam int VAL_W = 32;
  localparam int RNG_W = 10;

  typedef enum logic [1:0] {
    REQ_ASSIGN = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_kind_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_RD,
    ST_EVAL,
    ST_WR1,
    ST_WR2,
    ST_WR3,
    ST_DEC,
    ST_RET,
    ST_FIN
  } walk_state_t;

  // pending assignment of one node
  typedef struct packed {
    logic             flag;
    logic [VAL_W-1:0] pval;
  } mark_t;

  // memory strobes from the sequencer
  typedef struct packed {
    logic rd_en;
    logic tot_we;
    logic mark_we;
  } mem_ctl_t;

endpackage

/* rtl/rast_mem.sv */
// node storage: subtree totals and pending marks, registered reads
// depends on rast_pkg
module rast_mem #(
  parameter int NODE_W = 12
) (
  input  logic                   clk,
  input  rast_pkg::mem_ctl_t     ctl,
  input  logic [NODE_W-1:0]      rd_addr,
  input  logic [NODE_W-1:0]      tot_addr,
  input  logic [rast_pkg::SUM_W-1:0] tot_wdata,
  input  logic [NODE_W-1:0]      mark_addr,
  input  rast_pkg::mark_t        mark_wdata,
  output logic [rast_pkg::SUM_W-1:0] tot_q,
  output rast_pkg::mark_t        mark_q
);
  import rast_pkg::*;

  localparam int NODES = 1 << NODE_W;

  logic [SUM_W-1:0] tot_mem [NODES];
  mark_t            mark_mem [NODES];

  // totals memory
  always_ff @(posedge clk) begin
    if (ctl.tot_we) begin
      tot_mem[tot_addr] <= tot_wdata;
    end
    if (ctl.rd_en) begin
      tot_q <= tot_mem[rd_addr];
    end
  end

  // pending mark memory
  always_ff @(posedge clk) begin
    if (ctl.mark_we) begin
      mark_mem[mark_addr] <= mark_wdata;
    end
    if (ctl.rd_en) begin
      mark_q <= mark_mem[rd_addr];
    end
  end

endmodule

/* rtl/rast_walk.sv */
// tree walk sequencer: explicit frame stack, lazy push-down, clearing sweep
// depends on rast_pkg; drives rast_mem
module rast_walk #(
  parameter int POSITIONS = 1024,
  parameter int NODE_W    = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_kind,
  input  logic [rast_pkg::RNG_W-1:0] in_lo,
  input  logic [rast_pkg::RNG_W-1:0] in_hi,
  input  logic [rast_pkg::VAL_W-1:0] in_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rast_pkg::SUM_W-1:0] out_sum,
  output rast_pkg::mem_ctl_t         ctl,
  output logic [NODE_W-1:0]          rd_addr,
  output logic [NODE_W-1:0]          tot_addr,
  output logic [rast_pkg::SUM_W-1:0] tot_wdata,
  output logic [NODE_W-1:0]          mark_addr,
  output rast_pkg::mark_t            mark_wdata,
  input  logic [rast_pkg::SUM_W-1:0] tot_q,
  input  rast_pkg::mark_t            mark_q
);
  import rast_pkg::*;

  localparam int POS_W = $clog2(POSITIONS);
  localparam int CW    = (POS_W > RNG_W) ? POS_W : RNG_W;
  localparam int LEN_W = POS_W + 1;
  localparam int PRD_W = VAL_W + LEN_W;
  localparam int SD    = POS_W + 1;
  localparam int SI_W  = $clog2(SD);
  localparam int SP_W  = $clog2(SD + 1);
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'((1 << NODE_W) - 1);
  localparam logic [POS_W-1:0]  TOP_POS   = POS_W'(POSITIONS - 1);

  walk_state_t       state_r, state_nxt;
  logic [NODE_W-1:0] cnt_r, cnt_nxt;
  logic              query_r, query_nxt;
  logic [CW-1:0]     a_r, a_nxt, b_r, b_nxt;
  logic [VAL_W-1:0]  v_r, v_nxt;
  logic [NODE_W-1:0] n_r, n_nxt;
  logic [POS_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [SUM_W-1:0]  prod_r, prod_nxt;
  logic [SUM_W-1:0]  tot_r, tot_nxt;
  logic [SUM_W-1:0]  ret_r, ret_nxt;
  logic [VAL_W-1:0]  mval_r, mval_nxt;
  logic              flag_r, flag_nxt;
  logic              acov_r, acov_nxt;
  logic              outside_r, outside_nxt;
  logic              covered_r, covered_nxt;
  logic [SP_W-1:0]   sp_r, sp_nxt;
  logic              ovld_r, ovld_nxt;
  logic [SUM_W-1:0]  osum_r, osum_nxt;

  // frame stack, read at the top only
  logic [NODE_W-1:0] stk_n_r   [SD];
  logic [POS_W-1:0]  stk_lo_r  [SD];
  logic [POS_W-1:0]  stk_hi_r  [SD];
  logic              stk_ph_r  [SD];
  logic [SUM_W-1:0]  stk_acc_r [SD];
  logic              push_en, upd_en;

  logic [SI_W-1:0]   ti;
  logic [NODE_W-1:0] t_n;
  logic [POS_W-1:0]  t_lo, t_hi, t_mid, mid;
  logic              t_ph;
  logic [SUM_W-1:0]  t_acc, sum_res;
  logic [LEN_W-1:0]  len;
  logic [CW-1:0]     lo_c, hi_c;
  logic              outside_c, covered_c, acov_c;
  logic [VAL_W-1:0]  op_c;
  logic [PRD_W-1:0]  prod_full;
  logic [SUM_W-1:0]  new_tot;
  logic              touch;

  assign ti      = SI_W'(sp_r - SP_W'(1));
  assign t_n     = stk_n_r[ti];
  assign t_lo    = stk_lo_r[ti];
  assign t_hi    = stk_hi_r[ti];
  assign t_ph    = stk_ph_r[ti];
  assign t_acc   = stk_acc_r[ti];
  assign t_mid   = t_lo + ((t_hi - t_lo) >> 1);
  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign sum_res = t_acc + ret_r;

  // node classification against the request range
  assign lo_c      = CW'(lo_r);
  assign hi_c      = CW'(hi_r);
  assign outside_c = (hi_c < a_r) || (lo_c > b_r);
  assign covered_c = (lo_c >= a_r) && (hi_c <= b_r);
  assign acov_c    = !query_r && covered_c;
  assign len       = LEN_W'(hi_r) - LEN_W'(lo_r) + LEN_W'(1);
  assign op_c      = acov_c ? v_r : mark_q.pval;
  assign prod_full = PRD_W'(op_c) * PRD_W'(len);
  assign touch     = acov_r || flag_r;
  assign new_tot   = touch ? prod_r : tot_r;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = ovld_r;
  assign out_sum   = osum_r;

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      cnt_r   <= '0;
      sp_r    <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sp_r    <= sp_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    query_r   <= query_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    v_r       <= v_nxt;
    n_r       <= n_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    prod_r    <= prod_nxt;
    tot_r     <= tot_nxt;
    ret_r     <= ret_nxt;
    mval_r    <= mval_nxt;
    flag_r    <= flag_nxt;
    acov_r    <= acov_nxt;
    outside_r <= outside_nxt;
    covered_r <= covered_nxt;
    osum_r    <= osum_nxt;
  end

  // frame stack writes
  always_ff @(posedge clk) begin
    if (push_en) begin
      stk_n_r[sp_r[SI_W-1:0]]   <= n_r;
      stk_lo_r[sp_r[SI_W-1:0]]  <= lo_r;
      stk_hi_r[sp_r[SI_W-1:0]]  <= hi_r;
      stk_ph_r[sp_r[SI_W-1:0]]  <= 1'b0;
      stk_acc_r[sp_r[SI_W-1:0]] <= '0;
    end
    if (upd_en) begin
      stk_ph_r[ti]  <= 1'b1;
      stk_acc_r[ti] <= ret_r;
    end
  end

  // next state and memory strobes
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    query_nxt   = query_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    v_nxt       = v_r;
    n_nxt       = n_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    prod_nxt    = prod_r;
    tot_nxt     = tot_r;
    ret_nxt     = ret_r;
    mval_nxt    = mval_r;
    flag_nxt    = flag_r;
    acov_nxt    = acov_r;
    outside_nxt = outside_r;
    covered_nxt = covered_r;
    sp_nxt      = sp_r;
    osum_nxt    = osum_r;
    ovld_nxt    = ovld_r && !out_ready;
    push_en     = 1'b0;
    upd_en      = 1'b0;
    ctl         = '0;
    rd_addr     = n_r;
    tot_addr    = n_r;
    tot_wdata   = new_tot;
    mark_addr   = n_r;
    mark_wdata  = '0;

    case (state_r)
      // sweep every node to zero total and no mark
      ST_CLR: begin
        ctl.tot_we  = 1'b1;
        ctl.mark_we = 1'b1;
        tot_addr    = cnt_r;
        mark_addr   = cnt_r;
        tot_wdata   = '0;
        cnt_nxt     = cnt_r + NODE_W'(1);
        if (cnt_r == LAST_NODE) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          query_nxt = (in_kind == REQ_QUERY);
          a_nxt     = CW'(in_lo);
          b_nxt     = CW'(in_hi);
          v_nxt     = in_value;
          n_nxt     = NODE_W'(1);
          lo_nxt    = '0;
          hi_nxt    = TOP_POS;
          sp_nxt    = '0;
          case (in_kind)
            REQ_ASSIGN, REQ_QUERY: state_nxt = ST_RD;
            REQ_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = ST_CLR;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_RD: begin
        ctl.rd_en = 1'b1;
        state_nxt = ST_EVAL;
      end
      // classify, start the one multiply for this node
      ST_EVAL: begin
        prod_nxt    = SUM_W'(prod_full);
        tot_nxt     = tot_q;
        flag_nxt    = mark_q.flag;
        mval_nxt    = op_c;
        acov_nxt    = acov_c;
        outside_nxt = outside_c;
        covered_nxt = covered_c;
        state_nxt   = ST_WR1;
      end
      // apply pending or new assignment to this node
      ST_WR1: begin
        ctl.tot_we  = touch;
        ctl.mark_we = flag_r;
        tot_nxt     = new_tot;
        state_nxt   = (touch && (lo_r != hi_r)) ? ST_WR2 : ST_DEC;
      end
      ST_WR2: begin
        ctl.mark_we = 1'b1;
        mark_addr   = {n_r[NODE_W-2:0], 1'b0};
        mark_wdata  = '{flag: 1'b1, pval: mval_r};
        state_nxt   = ST_WR3;
      end
      ST_WR3: begin
        ctl.mark_we = 1'b1;
        mark_addr   = {n_r[NODE_W-2:0], 1'b1};
        mark_wdata  = '{flag: 1'b1, pval: mval_r};
        state_nxt   = ST_DEC;
      end
      ST_DEC: begin
        if (outside_r) begin
          ret_nxt   = query_r ? '0 : tot_r;
          state_nxt = ST_RET;
        end else if (covered_r) begin
          ret_nxt   = tot_r;
          state_nxt = ST_RET;
        end else begin
          push_en   = 1'b1;
          sp_nxt    = sp_r + SP_W'(1);
          n_nxt     = {n_r[NODE_W-2:0], 1'b0};
          hi_nxt    = mid;
          state_nxt = ST_RD;
        end
      end
      // hand a child result back to its parent frame; start the right child or end the walk
      ST_RET: begin
        if (sp_r == '0) begin
          state_nxt = query_r ? ST_FIN : ST_IDLE;
        end else if (!t_ph) begin
          upd_en    = 1'b1;
          n_nxt     = {t_n[NODE_W-2:0], 1'b1};
          lo_nxt    = t_mid + POS_W'(1);
          hi_nxt    = t_hi;
          state_nxt = ST_RD;
        end else begin
          ctl.tot_we = !query_r;
          tot_addr   = t_n;
          tot_wdata  = sum_res;
          ret_nxt    = sum_res;
          sp_nxt     = sp_r - SP_W'(1);
        end
      end
      ST_FIN: begin
        if (!ovld_r || out_ready) begin
          ovld_nxt  = 1'b1;
          osum_nxt  = ret_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n) sp_r <= SP_W'(SD))
    else $error("frame stack overflow");
  a_fin_query: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |-> query_r)
    else $error("result pending for a non-query item");
  a_rd_eval: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD |=> state_r == ST_EVAL)
    else $error("read not followed by evaluate");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR || state_r == ST_RET) |-> !in_ready)
    else $error("item taken during a walk or sweep");
`endif

endmodule

/* rtl/range_assign_range_sum_tree_top.sv */
// top level of the lazy range-assign / range-sum tree
// depends on rast_pkg, rast_mem and rast_walk
//
// Segment tree over POSITIONS positions. in_tuser selects assign, sum query,
// clear or no-op; only a query yields an output item. Each request walks the
// tree from the root through a frame stack, one node at a time: a node is
// read, evaluated and multiplied, written and decided on, with two more
// mark writes when a mark is pushed to its children, and a return step to
// its parent. A typical request over 1024 positions visits about 40 nodes,
// one after another through the serial node memory walk.
// Clear, and reset, sweep all 2**NODE_W node entries (4*POSITIONS rounded up
// to a power of two, 4096 for 1024 positions) at one a cycle, and no item is
// taken during the sweep.
module range_assign_range_sum_tree_top #(
  parameter int POSITIONS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // range_lo[9:0], range_hi[19:10], value[51:20]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // range_sum[41:0]
);
  import rast_pkg::*;

  localparam int NODE_W = $clog2(4 * POSITIONS);

  mem_ctl_t          ctl;
  logic [NODE_W-1:0] rd_addr, tot_addr, mark_addr;
  logic [SUM_W-1:0]  tot_wdata, tot_q, sum;
  mark_t             mark_wdata, mark_q;

  assign out_tdata = {6'b0, sum};

  rast_walk #(
    .POSITIONS(POSITIONS),
    .NODE_W   (NODE_W)
  ) u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_lo     (in_tdata[9:0]),
    .in_hi     (in_tdata[19:10]),
    .in_value  (in_tdata[51:20]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_sum   (sum),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .tot_addr  (tot_addr),
    .tot_wdata (tot_wdata),
    .mark_addr (mark_addr),
    .mark_wdata(mark_wdata),
    .tot_q     (tot_q),
    .mark_q    (mark_q)
  );

  rast_mem #(
    .NODE_W(NODE_W)
  ) u_mem (
    .clk       (clk),
    .ctl       (ctl),
    .rd_addr   (rd_addr),
    .tot_addr  (tot_addr),
    .tot_wdata (tot_wdata),
    .mark_addr (mark_addr),
    .mark_wdata(mark_wdata),
    .tot_q     (tot_q),
    .mark_q    (mark_q)
  );

endmodule

/* tb/tb.sv */
// testbench for the lazy range-assign / range-sum tree
// depends on rast_pkg and range_assign_range_sum_tree_top; checks query sums
// against a flat array of positions kept alongside the stream
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rast_pkg::*;

  localparam int NPOS = 1024;
  localparam int WATCH_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;

  always #4 clk = ~clk;

  range_assign_range_sum_tree_top #(.POSITIONS(NPOS)) dut (.*);

  // flat view of the positions; the tree holds the same sums
  logic [VAL_W-1:0] pos_val[NPOS];
  logic [SUM_W-1:0] sum_queue[$];
  int errors = 0;
  int idle_cycles = 0;
  int rx_wait = 0;
  int rx_draw = 0;
  bit stim_done = 1'b0;

  typedef struct {
    req_kind_t kind;
    int lo;
    int hi;
    logic [31:0] val;
    bit has_known;
    logic [SUM_W-1:0] known;
  } req_row_t;

  function automatic logic [SUM_W-1:0] range_total(int lo, int hi);
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int i = lo; i <= hi && i < NPOS; i++) acc += pos_val[i];
    return acc;
  endfunction

  // update the flat view and queue the expected sum of a query
  task automatic predict_item(req_kind_t kind, int lo, int hi, logic [31:0] val);
    case (kind)
      REQ_ASSIGN: begin
        for (int i = lo; i <= hi && i < NPOS; i++) pos_val[i] = val;
      end
      REQ_QUERY: sum_queue.push_back(range_total(lo, hi));
      REQ_CLEAR: begin
        for (int i = 0; i < NPOS; i++) pos_val[i] = '0;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(req_kind_t kind, int lo, int hi, logic [31:0] val);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {4'b0, val, hi[9:0], lo[9:0]};
    do @(posedge clk); while (!in_tready);
    predict_item(kind, lo, hi, val);
  endtask

  // receiver side with a random wait per item, and compare
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (sum_queue.size() == 0) begin
          $display("%0t: unexpected sum, expected none, actual %0d", $time, out_tdata[41:0]);
          errors++;
        end else begin
          if (out_tdata[41:0] !== sum_queue[0] || out_tdata[47:42] !== 6'd0) begin
            $display("%0t: range_sum mismatch, expected %0d, actual %0d",
                     $time, sum_queue[0], out_tdata);
            errors++;
          end
          void'(sum_queue.pop_front());
        end
        rx_draw = $urandom_range(0, 3);
        rx_wait <= rx_draw;
        out_tready <= (rx_draw == 0);
      end else if (rx_wait > 0) begin
        if (out_tvalid) begin
          rx_wait <= rx_wait - 1;
          out_tready <= (rx_wait == 1);
        end
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  req_row_t rows[$];
  localparam logic [31:0] VMAX = 32'hFFFF_FFFF;

  initial begin
    int lo;
    int hi;
    int pick;
    int shape;
    int span;
    req_kind_t kind;
    for (int i = 0; i < NPOS; i++) pos_val[i] = '0;
    // directed rows: known sums where obvious, else predicted
    rows = '{
      '{REQ_QUERY, 0, 1023, 0, 1, 0},
      '{REQ_ASSIGN, 0, 1023, VMAX, 0, 0},
      '{REQ_QUERY, 0, 1023, 0, 1, 42'(64'(VMAX) * 1024)},
      '{REQ_QUERY, 5, 5, 0, 1, 42'(VMAX)},
      '{REQ_QUERY, 7, 3, 0, 1, 0},
      '{REQ_ASSIGN, 9, 2, 32'd77, 0, 0},
      '{REQ_ASSIGN, 100, 357, 32'h5555_AAAA, 0, 0},
      '{REQ_QUERY, 0, 511, 0, 0, 0},
      '{REQ_QUERY, 300, 900, 0, 0, 0},
      '{REQ_NONE, 0, 1023, VMAX, 0, 0},
      '{REQ_QUERY, 1023, 1023, 0, 1, 42'(VMAX)},
      '{REQ_ASSIGN, 1023, 1023, 32'd1, 0, 0},
      '{REQ_ASSIGN, 0, 0, 32'd0, 0, 0},
      '{REQ_QUERY, 0, 1023, 0, 0, 0},
      '{REQ_CLEAR, 0, 0, 0, 0, 0},
      '{REQ_QUERY, 0, 1023, 0, 1, 0},
      '{REQ_ASSIGN, 1, 1022, 32'hAAAA_5555, 0, 0},
      '{REQ_ASSIGN, 500, 520, 32'd3, 0, 0},
      '{REQ_QUERY, 499, 521, 0, 0, 0},
      '{REQ_QUERY, 0, 1023, 0, 0, 0},
      '{REQ_CLEAR, 1023, 1023, VMAX, 0, 0},
      '{REQ_QUERY, 200, 800, 0, 1, 0}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (rows[r]) begin
      if (rows[r].has_known) begin
        if (range_total(rows[r].lo, rows[r].hi) !== rows[r].known) begin
          $display("%0t: table sum mismatch, expected %0d, actual %0d",
                   $time, rows[r].known, range_total(rows[r].lo, rows[r].hi));
          errors++;
        end
      end
      send_item(rows[r].kind, rows[r].lo, rows[r].hi, rows[r].val);
    end
    // random part: mostly assigns and queries, rare clears and no-ops
    for (int n = 0; n < 400; n++) begin
      if (n == 200) begin
        in_tvalid <= 1'b0;
        wait (sum_queue.size() == 0);
        @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      kind = pick < 45 ? REQ_ASSIGN : pick < 94 ? REQ_QUERY :
             pick < 97 ? REQ_CLEAR : REQ_NONE;
      shape = $urandom_range(0, 9);
      lo = $urandom_range(0, 1023);
      if (shape == 0) hi = $urandom_range(0, 1023);
      else if (shape < 7) begin
        span = $urandom_range(0, 40);
        hi = lo + span > 1023 ? 1023 : lo + span;
      end
      else hi = $urandom_range(lo, 1023);
      send_item(kind, lo, hi,
                ($urandom_range(0, 7) == 0) ? VMAX : 32'($urandom()));
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // drain and finish
  initial begin
    wait (stim_done);
    wait (sum_queue.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
